FILE: sv/rrk_pkg.sv
package rrk_pkg;

    typedef enum logic [1:0] {
        FUNC_LOAD_WEIGHT = 2'd0,
        FUNC_LOAD_DRIVE  = 2'd1,
        FUNC_STEP        = 2'd2,
        FUNC_CLEAR       = 2'd3
    } func_t;

    typedef enum logic [0:0] {
        CFG_STEP_SIZE  = 1'd0,
        CFG_INPUT_GAIN = 1'd1
    } cfg_idx_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MAC_ADDR,
        ST_MAC_MUL,
        ST_MAC_ACC,
        ST_GAIN_MUL,
        ST_GAIN_ACC,
        ST_TANH_MUL,
        ST_SLOPE,
        ST_H_MUL,
        ST_UPDATE,
        ST_FINAL,
        ST_EMIT
    } state_t;

    function automatic logic [16:0] tanh_tab(input logic [4:0] k);
        logic [16:0] t;
        begin
            unique case (k)
                5'd0:  t = 17'd0;
                5'd1:  t = 17'd16051;
                5'd2:  t = 17'd30285;
                5'd3:  t = 17'd41625;
                5'd4:  t = 17'd49912;
                5'd5:  t = 17'd55593;
                5'd6:  t = 17'd59320;
                5'd7:  t = 17'd61694;
                5'd8:  t = 17'd63179;
                5'd9:  t = 17'd64096;
                5'd10: t = 17'd64659;
                5'd11: t = 17'd65003;
                5'd12: t = 17'd65212;
                5'd13: t = 17'd65339;
                5'd14: t = 17'd65417;
                5'd15: t = 17'd65464;
                default: t = 17'd65492;
            endcase
            return t;
        end
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        logic signed [31:0] r;
        begin
            if (v > 64'sd2147483647)
                r = 32'sh7FFF_FFFF;
            else if (v < -64'sd2147483648)
                r = 32'sh8000_0000;
            else
                r = v[31:0];
            return r;
        end
    endfunction

endpackage

FILE: sv/rrk_ram.sv
module rrk_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

FILE: sv/reservoir_rk4_integrator.sv
// Channel   Direction  Handshake          Payload
// in        input      in_valid/in_ready  func, row, col, value
// out       output     out_valid/out_ready neuron_index, state_value, last
// cfg       input      cfg_valid/cfg_ready cfg_index, cfg_data
//
// Loads and clears are taken in the idle state. A step runs four slope passes
// on one shared 33x33 multiplier: per neuron a multiply-accumulate over every
// weight, then gain, tanh, slope, step and update, and after the fourth pass a
// final update per neuron, then one result per cycle as out_ready allows.
// in_ready is low from acceptance of a step until its last result is taken.
// Reset clears the states and sets the registers to their defaults; weights
// and drive are undefined until loaded.
module reservoir_rk4_integrator
    import rrk_pkg::*;
#(
    parameter int NEURONS   = 16,
    parameter int FRAC_BITS = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [1:0]         func,
    input  logic [5:0]         row,
    input  logic [5:0]         col,
    input  logic signed [31:0] value,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [5:0]         neuron_index,
    output logic signed [31:0] state_value,
    output logic               last,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic               cfg_index,
    input  logic [16:0]        cfg_data
);

    localparam int NB = (NEURONS > 1) ? $clog2(NEURONS) : 1;
    localparam int WB = $clog2(NEURONS * NEURONS);

    state_t state_reg, state_next;
    logic [16:0] step_size_reg, input_gain_reg;
    logic [1:0]  stage_reg;
    logic [NB-1:0] i_reg, j_reg;
    logic signed [31:0] x_reg  [NEURONS];
    logic signed [31:0] pt_reg [NEURONS];
    logic signed [31:0] pt_next_reg [NEURONS];
    logic signed [34:0] ss_reg [NEURONS];
    logic signed [31:0] drive_reg [NEURONS];
    logic signed [51:0] acc_reg;
    logic signed [63:0] prod_reg;
    logic signed [31:0] ta_reg;
    logic [16:0] ty0_reg;
    logic signed [31:0] slope_reg;
    logic [NB-1:0] out_idx_reg;

    // Weight memory
    logic w_we;
    logic [WB-1:0] w_waddr, w_raddr;
    logic [31:0] w_rdata;

    assign w_we    = in_valid && in_ready && func == FUNC_LOAD_WEIGHT
                     && row < NEURONS && col < NEURONS;
    assign w_waddr = WB'(row * NEURONS + col);
    assign w_raddr = WB'(i_reg * NEURONS + j_reg);

    rrk_ram #(.WIDTH(32), .DEPTH(NEURONS * NEURONS)) u_wram (
        .clk   (clk),
        .we    (w_we),
        .waddr (w_waddr),
        .wdata (value),
        .raddr (w_raddr),
        .rdata (w_rdata)
    );

    assign in_ready  = state_reg == ST_IDLE;
    assign cfg_ready = state_reg == ST_IDLE;

    // Shared multiplier operand selection
    logic signed [32:0] mul_a, mul_b;
    logic signed [65:0] mul_p;
    logic [32:0] ta_mag;
    logic [39:0] u_abs;
    logic [4:0]  tk;
    logic [16:0] ty1;
    always_comb
    begin
        ta_mag = (ta_reg < 0) ? 33'(-33'(ta_reg)) : 33'(ta_reg);
        if (FRAC_BITS >= 16)
            u_abs = 40'(ta_mag) >> (FRAC_BITS - 16);
        else
            u_abs = 40'(ta_mag) << (16 - FRAC_BITS);
        // hold the last table value from 4.0 up
        tk  = (u_abs >= 40'd262144) ? 5'd16 : 5'(u_abs >> 14);
        ty1 = tanh_tab(5'((tk == 5'd16) ? 5'd16 : tk + 5'd1));
        unique case (state_reg)
            ST_MAC_MUL:
            begin
                mul_a = 33'(signed'(w_rdata));
                mul_b = 33'(pt_reg[j_reg]);
            end
            ST_GAIN_MUL:
            begin
                mul_a = 33'(signed'({1'b0, input_gain_reg}));
                mul_b = 33'(drive_reg[i_reg]);
            end
            ST_TANH_MUL:
            begin
                mul_a = 33'(signed'({1'b0, ty1 - tanh_tab(tk)}));
                mul_b = 33'(signed'({19'd0, u_abs[13:0]}));
            end
            default:
            begin
                mul_a = 33'(signed'({1'b0, step_size_reg}));
                mul_b = 33'(slope_reg);
            end
        endcase
        mul_p = mul_a * mul_b;
    end

    // Floor scaling of the registered product
    logic signed [63:0] scaled;
    assign scaled = prod_reg >>> FRAC_BITS;

    // Slope times step, product registered during ST_H_MUL
    logic signed [31:0] k_cur;
    assign k_cur = sat32(scaled);

    // Tanh reconstruction
    logic [16:0] ty;
    logic signed [31:0] tanh_v;
    always_comb
    begin
        ty = 17'(ty0_reg + 17'(prod_reg >> 14));
        if (FRAC_BITS >= 16)
            tanh_v = 32'(signed'({15'd0, ty}) <<< (FRAC_BITS - 16));
        else
            tanh_v = 32'(signed'({15'd0, ty}) >>> (16 - FRAC_BITS));
        if (ta_reg < 0)
            tanh_v = -tanh_v;
    end

    // Stage point and final update
    logic signed [31:0] k_half;
    logic signed [31:0] new_pt;
    logic signed [34:0] ss_new;
    logic [34:0] s_mag;
    logic [16:0] s_hi;
    logic [18:0] s_t;
    logic [39:0] t_prod;
    logic [31:0] q6;
    logic signed [34:0] div6;
    logic signed [31:0] x_new;
    always_comb
    begin
        k_half = k_cur >>> 1;
        new_pt = (stage_reg == 2'd2) ? sat32(64'(x_reg[i_reg]) + 64'(k_cur))
                                     : sat32(64'(x_reg[i_reg]) + 64'(k_half));
        unique case (stage_reg)
            2'd0:    ss_new = 35'(k_cur);
            2'd3:    ss_new = ss_reg[i_reg] + 35'(k_cur);
            default: ss_new = ss_reg[i_reg] + (35'(k_cur) <<< 1);
        endcase
        // Divide the magnitude by 6 using 2^17 = 6*21845 + 2, truncate toward zero
        s_mag  = ss_reg[i_reg][34] ? 35'(-ss_reg[i_reg]) : 35'(ss_reg[i_reg]);
        s_hi   = s_mag[33:17];
        s_t    = 19'({s_hi, 1'b0}) + 19'(s_mag[16:0]);
        t_prod = 40'(s_t) * 40'd699051;
        q6     = 32'(s_hi) * 32'd21845 + 32'(t_prod >> 22);
        div6   = ss_reg[i_reg][34] ? -35'(q6) : 35'(q6);
        x_new  = sat32(64'(x_reg[i_reg]) + 64'(div6));
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
                if (in_valid && func == FUNC_STEP)
                    state_next = ST_MAC_ADDR;
            ST_MAC_ADDR: state_next = ST_MAC_MUL;
            ST_MAC_MUL:  state_next = ST_MAC_ACC;
            ST_MAC_ACC:
                state_next = (j_reg == NB'(NEURONS - 1)) ? ST_GAIN_MUL : ST_MAC_ADDR;
            ST_GAIN_MUL: state_next = ST_GAIN_ACC;
            ST_GAIN_ACC: state_next = ST_TANH_MUL;
            ST_TANH_MUL: state_next = ST_SLOPE;
            ST_SLOPE:    state_next = ST_H_MUL;
            ST_H_MUL:    state_next = ST_UPDATE;
            ST_UPDATE:
                if (i_reg != NB'(NEURONS - 1))
                    state_next = ST_MAC_ADDR;
                else if (stage_reg == 2'd3)
                    state_next = ST_FINAL;
                else
                    state_next = ST_MAC_ADDR;
            ST_FINAL:
                if (i_reg == NB'(NEURONS - 1))
                    state_next = ST_EMIT;
            ST_EMIT:
                if (out_ready && out_idx_reg == NB'(NEURONS - 1))
                    state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    // Outputs
    always_comb
    begin
        out_valid    = state_reg == ST_EMIT;
        neuron_index = 6'(out_idx_reg);
        state_value  = x_reg[out_idx_reg];
        last         = out_idx_reg == NB'(NEURONS - 1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            step_size_reg  <= 17'd655;
            input_gain_reg <= 17'd786;
            stage_reg      <= '0;
            i_reg          <= '0;
            j_reg          <= '0;
            out_idx_reg    <= '0;
            for (int n = 0; n < NEURONS; n++)
            begin
                x_reg[n] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            // Configuration writes
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == CFG_STEP_SIZE)
                    step_size_reg <= cfg_data;
                else
                    input_gain_reg <= cfg_data;
            end
            unique case (state_reg)
                ST_IDLE:
                    if (in_valid)
                    begin
                        if (func == FUNC_CLEAR)
                        begin
                            for (int n = 0; n < NEURONS; n++)
                            begin
                                x_reg[n] <= '0;
                            end
                        end
                        if (func == FUNC_STEP)
                        begin
                            stage_reg <= '0;
                            i_reg     <= '0;
                            j_reg     <= '0;
                        end
                    end
                ST_MAC_ACC:
                    j_reg <= (j_reg == NB'(NEURONS - 1)) ? '0 : j_reg + 1'b1;
                ST_UPDATE:
                    if (i_reg == NB'(NEURONS - 1))
                    begin
                        i_reg     <= '0;
                        stage_reg <= stage_reg + 1'b1;
                    end
                    else
                        i_reg <= i_reg + 1'b1;
                ST_FINAL:
                begin
                    x_reg[i_reg] <= x_new;
                    i_reg <= (i_reg == NB'(NEURONS - 1)) ? '0 : i_reg + 1'b1;
                    out_idx_reg <= '0;
                end
                ST_EMIT:
                    if (out_ready)
                        out_idx_reg <= out_idx_reg + 1'b1;
                default: ;
            endcase
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready && func == FUNC_LOAD_DRIVE && row < NEURONS)
            drive_reg[NB'(row)] <= value;
        if (in_valid && in_ready && func == FUNC_STEP)
        begin
            for (int n = 0; n < NEURONS; n++)
            begin
                pt_reg[n] <= x_reg[n];
            end
        end
        prod_reg <= 64'(mul_p);
        unique case (state_reg)
            ST_MAC_ADDR:
                if (j_reg == '0)
                    acc_reg <= '0;
            ST_MAC_ACC:  acc_reg <= acc_reg + 52'(scaled);
            ST_GAIN_ACC:
            begin
                ta_reg  <= sat32(64'(acc_reg) + scaled);
            end
            ST_TANH_MUL: ty0_reg <= tanh_tab(tk);
            ST_SLOPE:
                slope_reg <= sat32(64'(tanh_v) - 64'(pt_reg[i_reg]));
            ST_H_MUL: ;
            ST_UPDATE:
            begin
                ss_reg[i_reg] <= ss_new;
                if (i_reg == NB'(NEURONS - 1))
                begin
                    for (int n = 0; n < NEURONS - 1; n++)
                    begin
                        pt_reg[n] <= pt_next_reg[n];
                    end
                    pt_reg[NEURONS - 1] <= new_pt;
                end
                else
                    pt_next_reg[i_reg] <= new_pt;
            end
            default: ;
        endcase
    end

endmodule
